[hdl/ipv4_acl_pkg.sv]
`default_nettype none

package ipv4_acl_pkg;

  localparam int unsigned RulesPerListDefault = 8;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PrefW  = 6;
  localparam int unsigned SlotW  = 3;
  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 8;

  localparam logic CmdQuery = 1'b0;
  localparam logic CmdWrite = 1'b1;

  localparam logic ListAllow = 1'b0;
  localparam logic ListDeny  = 1'b1;

  localparam logic [AddrW-1:0] AllOnes = 32'hFFFF_FFFF;
  localparam logic [PrefW-1:0] FullLen = 6'd32;

  // Item as it moves from cell to cell
  typedef struct packed {
    logic             valid;
    logic             cmd;
    logic             list;
    logic [SlotW-1:0] slot;
    logic [AddrW-1:0] rule_addr;
    logic [PrefW-1:0] rule_len;
    logic             rule_en;
    logic [AddrW-1:0] query_addr;
    logic             hit_allow;
    logic             hit_deny;
  } acl_item_t;

  // Leading-ones mask; lengths above 32 compare the whole address
  function automatic logic [AddrW-1:0] prefix_mask(input logic [PrefW-1:0] len);
    logic [AddrW-1:0] m;
    if (len >= FullLen) begin
      m = AllOnes;
    end else begin
      m = ~(AllOnes >> len);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[hdl/ipv4_acl_cell.sv]
`default_nettype none

module ipv4_acl_cell
  import ipv4_acl_pkg::*;
#(
  parameter int unsigned CELL_IDX = 0
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      advance_i,
  input  wire acl_item_t item_i,
  output acl_item_t      item_o
);

  logic [AddrW-1:0] allow_addr_q;
  logic [PrefW-1:0] allow_len_q;
  logic             allow_valid_q;
  logic [AddrW-1:0] deny_addr_q;
  logic [PrefW-1:0] deny_len_q;
  logic             deny_valid_q;

  logic             slot_sel;
  logic             wr_allow;
  logic             wr_deny;
  logic             is_query;
  logic             allow_match;
  logic             deny_match;
  acl_item_t        item_d;
  acl_item_t        item_q;
  logic             valid_q;

  // Decode a write aimed at this cell
  assign slot_sel = (32'(item_i.slot) == 32'(CELL_IDX));
  assign wr_allow = advance_i && item_i.valid && (item_i.cmd == CmdWrite) && slot_sel
                    && (item_i.list == ListAllow);
  assign wr_deny  = advance_i && item_i.valid && (item_i.cmd == CmdWrite) && slot_sel
                    && (item_i.list == ListDeny);
  assign is_query = item_i.valid && (item_i.cmd == CmdQuery);

  // Compare the query against both stored rules
  assign allow_match = allow_valid_q &&
    (((item_i.query_addr ^ allow_addr_q) & prefix_mask(allow_len_q)) == '0);
  assign deny_match  = deny_valid_q &&
    (((item_i.query_addr ^ deny_addr_q) & prefix_mask(deny_len_q)) == '0);

  // Accumulate hits and hand the item on
  always_comb begin
    item_d           = item_i;
    item_d.hit_allow = item_i.hit_allow || (is_query && allow_match);
    item_d.hit_deny  = item_i.hit_deny  || (is_query && deny_match);
  end

  // Valid marks of the stored rules
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_valid_q <= 1'b0;
      deny_valid_q  <= 1'b0;
    end else begin
      if (wr_allow) begin
        allow_valid_q <= item_i.rule_en;
      end
      if (wr_deny) begin
        deny_valid_q <= item_i.rule_en;
      end
    end
  end

  // Rule payload
  always_ff @(posedge clk_i) begin
    if (wr_allow) begin
      allow_addr_q <= item_i.rule_addr;
      allow_len_q  <= item_i.rule_len;
    end
    if (wr_deny) begin
      deny_addr_q <= item_i.rule_addr;
      deny_len_q  <= item_i.rule_len;
    end
  end

  // Stage register: valid under reset, payload plain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_i) begin
      valid_q <= item_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      item_q <= item_d;
    end
  end

  // Present the staged item with its reset-safe valid
  always_comb begin
    item_o       = item_q;
    item_o.valid = valid_q;
  end

endmodule

`default_nettype wire

[hdl/ipv4_cidr_allow_deny_filter_core.sv]
`default_nettype none
// Channel   Direction  Fields (lowest bit first)
// s_axis    in         tuser: cmd; tdata: rule_list, rule_slot, rule_address,
//                      rule_prefix_length, rule_enable, query_address
// m_axis    out        tdata: permitted, hit_allow, hit_deny (one per query)
//
// One item enters per cycle while the output does not stall. Each item walks the
// row of RULES_PER_LIST cells, one cell per cycle, and a query result then passes
// the output register. Writes travel the same row and give no result.
// Reset clears every rule's valid mark and all stage valids.
// A stalled output holds the whole row, and s_axis_tready falls with it.

module ipv4_cidr_allow_deny_filter_core
  import ipv4_acl_pkg::*;
#(
  parameter int unsigned RULES_PER_LIST = RulesPerListDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // rule_list[0], rule_slot[3:1], rule_address[35:4], rule_prefix_length[41:36],
  // rule_enable[42], query_address[74:43], zero fill[79:75]
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  // cmd[0]
  input  wire logic                s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // permitted[0], hit_allow[1], hit_deny[2], zero fill[7:3]
  output logic [OutDataW-1:0]      m_axis_tdata
);

  acl_item_t        chain [RULES_PER_LIST+1];
  logic             advance;
  logic             out_valid_q;
  logic             out_valid_d;
  logic [2:0]       out_data_q;
  acl_item_t        tail;

  // Whole row moves unless a finished result waits
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;

  // Unpack the incoming transfer into the head of the row
  always_comb begin
    chain[0].valid      = s_axis_tvalid;
    chain[0].cmd        = s_axis_tuser;
    chain[0].list       = s_axis_tdata[0];
    chain[0].slot       = s_axis_tdata[3:1];
    chain[0].rule_addr  = s_axis_tdata[35:4];
    chain[0].rule_len   = s_axis_tdata[41:36];
    chain[0].rule_en    = s_axis_tdata[42];
    chain[0].query_addr = s_axis_tdata[74:43];
    chain[0].hit_allow  = 1'b0;
    chain[0].hit_deny   = 1'b0;
  end

  for (genvar k = 0; k < RULES_PER_LIST; k++) begin : g_cell
    ipv4_acl_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .advance_i(advance),
      .item_i   (chain[k]),
      .item_o   (chain[k+1])
    );
  end

  assign tail        = chain[RULES_PER_LIST];
  assign out_valid_d = tail.valid && (tail.cmd == CmdQuery);

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {tail.hit_deny, tail.hit_allow, tail.hit_allow || !tail.hit_deny};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OutDataW-3){1'b0}}, out_data_q};

endmodule

`default_nettype wire
